>>> design/zcpd_pkg.sv
// ----------------------------------------------------------------------------
// zcpd_pkg
// Constants shared by the zero-crossing phase detector and its channels.
// ----------------------------------------------------------------------------
package zcpd_pkg;

  localparam int PERIOD_W = 24;
  localparam int RAD_W    = 16;
  localparam int DEG_W    = 15;
  localparam int TICK_W   = 32;
  localparam int FRAC_W   = 16;
  localparam int DIV_W    = 40;
  localparam int CNT_W    = 6;
  localparam int PROD_W   = 64;
  localparam int DPROD_W  = 38;

  localparam logic [TICK_W-1:0]  ONE_Q16     = 32'h0001_0000;
  localparam logic [31:0]        TWOPI_Q29   = 32'd3373259426;
  localparam logic [RAD_W-1:0]   PI_Q13      = 16'd25736;
  localparam logic [RAD_W-1:0]   TWOPI_Q13   = 16'd51472;
  localparam logic [16:0]        THREEPI_Q13 = 17'd77208;
  localparam logic [21:0]        RAD2DEG_Q16 = 22'd3754937;
  localparam logic [DPROD_W-1:0] DEG_HALF    = 38'h00_0040_0000;

  localparam logic [CNT_W-1:0] FRAC_STEPS  = 6'd17;
  localparam logic [CNT_W-1:0] PHASE_STEPS = 6'd40;

endpackage

>>> design/zcpd_in_if.sv
// ----------------------------------------------------------------------------
// zcpd_in_if
// Sample channel: one sample pair and the current period per request.
// ----------------------------------------------------------------------------
interface zcpd_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                             valid;
  logic                             ready;
  logic signed [SAMPLE_WIDTH-1:0]   sample_a;
  logic signed [SAMPLE_WIDTH-1:0]   sample_b;
  logic [zcpd_pkg::PERIOD_W-1:0]    period_samples;

  modport source (output valid, sample_a, sample_b, period_samples, input ready);
  modport sink   (input valid, sample_a, sample_b, period_samples, output ready);
endinterface

>>> design/zcpd_out_if.sv
// ----------------------------------------------------------------------------
// zcpd_out_if
// Phase channel: measured phase in radians and degrees per request.
// ----------------------------------------------------------------------------
interface zcpd_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [zcpd_pkg::RAD_W-1:0] phase_radians;
  logic signed [zcpd_pkg::DEG_W-1:0] phase_degrees;

  modport source (output valid, phase_radians, phase_degrees, input ready);
  modport sink   (input valid, phase_radians, phase_degrees, output ready);
endinterface

>>> design/zero_cross_phase_detector_top.sv
// ----------------------------------------------------------------------------
// zero_cross_phase_detector_top
// Interpolated zero-crossing phase detector, B relative to A.
// ----------------------------------------------------------------------------
// One shared restoring divider does every division, one quotient bit a cycle.
// A sample pair with no crossing only advances the tick count. Arming on an A
// crossing adds a division for the interpolated fraction. A B crossing while
// armed adds a division for its fraction, the 32x32 multiply and rounding add,
// the phase division and the degree step; a zero period skips the multiply and
// division. The degree step waits while the previous phase is still waiting
// in the output register. The output register holds a finished phase while
// the next sample pair is taken.
module zero_cross_phase_detector_top #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  zcpd_in_if.sink     samples,
  zcpd_out_if.source  phase
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int DV_W  = (SW > zcpd_pkg::PERIOD_W) ? SW : zcpd_pkg::PERIOD_W;
  localparam int DIV_W = zcpd_pkg::DIV_W;
  localparam int TW    = zcpd_pkg::TICK_W;
  localparam int RW    = zcpd_pkg::RAD_W;
  localparam int DW    = zcpd_pkg::DEG_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV_A = 3'd1;
  localparam logic [2:0] S_DIV_B = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_ADD   = 3'd4;
  localparam logic [2:0] S_DIV_P = 3'd5;
  localparam logic [2:0] S_DEG   = 3'd6;

  logic [2:0]                        state;
  logic [SW-1:0]                     prev_a;
  logic [SW-1:0]                     prev_b;
  logic [TW-1:0]                     tick_count;
  logic                              armed;
  logic                              fire;
  logic [zcpd_pkg::PERIOD_W-1:0]     period;
  logic [SW-1:0]                     b_num;
  logic [SW-1:0]                     b_den;
  logic [DV_W-1:0]                   div_rem;
  logic [DV_W-1:0]                   div_den;
  logic [DIV_W-1:0]                  div_dvd;
  logic [DIV_W-1:0]                  div_quo;
  logic [zcpd_pkg::CNT_W-1:0]        div_cnt;
  logic [zcpd_pkg::PROD_W-1:0]       prod;
  logic                              neg;
  logic [RW-1:0]                     rad;
  logic                              out_valid;
  logic [RW-1:0]                     out_rad;
  logic [DW-1:0]                     out_deg;

  logic                              accept;
  logic                              arm_c;
  logic                              fire_c;
  logic [SW:0]                       a_den_w;
  logic [SW:0]                       b_den_w;
  logic [SW:0]                       b_num_w;
  logic [DV_W:0]                     div_sh;
  logic [DV_W+1:0]                   div_diff;
  logic                              div_bit;
  logic [DV_W-1:0]                   div_rem_next;
  logic [DIV_W-1:0]                  div_quo_next;
  logic                              div_last;
  logic                              div_step;
  logic [TW-1:0]                     frac;
  logic [TW-1:0]                     tick_mag;
  logic [zcpd_pkg::PROD_W-1:0]       prod_rnd;
  logic [RW-1:0]                     rad_p;
  logic [RW-1:0]                     rad_mag;
  logic [zcpd_pkg::DPROD_W-1:0]      deg_prod;
  logic [DW-1:0]                     deg_mag;
  logic [DW-1:0]                     deg;
  logic                              out_load;

  assign accept        = samples.valid && samples.ready;
  assign samples.ready = (state == S_IDLE);

  assign arm_c   = prev_a[SW-1] && !samples.sample_a[SW-1] && !armed;
  assign fire_c  = prev_b[SW-1] && !samples.sample_b[SW-1] && (armed || arm_c);
  assign a_den_w = {samples.sample_a[SW-1], samples.sample_a} - {prev_a[SW-1], prev_a};
  assign b_den_w = {samples.sample_b[SW-1], samples.sample_b} - {prev_b[SW-1], prev_b};
  assign b_num_w = (SW+1)'(0) - {prev_b[SW-1], prev_b};

  // shared divider step
  assign div_sh       = {div_rem, div_dvd[DIV_W-1]};
  assign div_diff     = {1'b0, div_sh} - {2'b00, div_den};
  assign div_bit      = !div_diff[DV_W+1];
  assign div_rem_next = div_bit ? div_diff[DV_W-1:0] : div_sh[DV_W-1:0];
  assign div_quo_next = {div_quo[DIV_W-2:0], div_bit};
  assign div_last     = (div_cnt == zcpd_pkg::CNT_W'(1));
  assign frac         = TW'(div_quo_next[zcpd_pkg::FRAC_W:0]);
  // the A fraction hands straight over to the B fraction on a same-sample fire
  assign div_step     = (state == S_DIV_B) || (state == S_DIV_P) ||
                        ((state == S_DIV_A) && !(div_last && fire));

  assign tick_mag = tick_count[TW-1] ? (TW'(0) - tick_count) : tick_count;
  assign prod_rnd = prod + (zcpd_pkg::PROD_W'(period) << 23);

  always_comb begin
    if (neg) begin
      if (div_quo_next <= DIV_W'(zcpd_pkg::PI_Q13)) begin
        rad_p = RW'(0) - div_quo_next[RW-1:0];
      end else begin
        rad_p = RW'(0) - zcpd_pkg::PI_Q13;
      end
    end else if (div_quo_next < DIV_W'(zcpd_pkg::PI_Q13)) begin
      rad_p = div_quo_next[RW-1:0];
    end else if (div_quo_next <= DIV_W'(zcpd_pkg::THREEPI_Q13)) begin
      rad_p = div_quo_next[RW-1:0] - zcpd_pkg::TWOPI_Q13;
    end else begin
      rad_p = zcpd_pkg::PI_Q13;
    end
  end

  assign rad_mag  = rad[RW-1] ? (RW'(0) - rad) : rad;
  assign deg_prod = zcpd_pkg::DPROD_W'(rad_mag) * zcpd_pkg::DPROD_W'(zcpd_pkg::RAD2DEG_Q16)
                    + zcpd_pkg::DEG_HALF;
  assign deg_mag  = deg_prod[zcpd_pkg::DPROD_W-1:23];
  assign deg      = rad[RW-1] ? (DW'(0) - deg_mag) : deg_mag;
  assign out_load = (state == S_DEG) && (!out_valid || phase.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      prev_a     <= '0;
      prev_b     <= '0;
      tick_count <= '0;
      armed      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (phase.ready && !out_load) begin
        out_valid <= 1'b0;
      end
      if (div_step) begin
        div_rem <= div_rem_next;
        div_quo <= div_quo_next;
        div_dvd <= {div_dvd[DIV_W-2:0], 1'b0};
        div_cnt <= div_cnt - zcpd_pkg::CNT_W'(1);
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            prev_a <= samples.sample_a;
            prev_b <= samples.sample_b;
            period <= samples.period_samples;
            fire   <= fire_c;
            armed  <= (armed || arm_c) && !fire_c;
            b_num  <= b_num_w[SW-1:0];
            b_den  <= b_den_w[SW-1:0];
            if (arm_c) begin
              div_rem <= DV_W'(samples.sample_a[SW-1:1]);
              div_dvd <= {samples.sample_a[0], (DIV_W-1)'(0)};
              div_den <= DV_W'(a_den_w[SW-1:0]);
              div_quo <= '0;
              div_cnt <= zcpd_pkg::FRAC_STEPS;
              state   <= S_DIV_A;
            end else if (fire_c) begin
              div_rem <= DV_W'(b_num_w[SW-1:1]);
              div_dvd <= {b_num_w[0], (DIV_W-1)'(0)};
              div_den <= DV_W'(b_den_w[SW-1:0]);
              div_quo <= '0;
              div_cnt <= zcpd_pkg::FRAC_STEPS;
              state   <= S_DIV_B;
            end else begin
              tick_count <= tick_count + zcpd_pkg::ONE_Q16;
            end
          end
        end
        S_DIV_A: begin
          if (div_last) begin
            if (fire) begin
              tick_count <= frac;
              div_rem    <= DV_W'(b_num[SW-1:1]);
              div_dvd    <= {b_num[0], (DIV_W-1)'(0)};
              div_den    <= DV_W'(b_den);
              div_quo    <= '0;
              div_cnt    <= zcpd_pkg::FRAC_STEPS;
              state      <= S_DIV_B;
            end else begin
              tick_count <= frac + zcpd_pkg::ONE_Q16;
              state      <= S_IDLE;
            end
          end
        end
        S_DIV_B: begin
          if (div_last) begin
            tick_count <= tick_count + frac - zcpd_pkg::ONE_Q16;
            state      <= S_MUL;
          end
        end
        S_MUL: begin
          tick_count <= tick_count + zcpd_pkg::ONE_Q16;
          neg        <= tick_count[TW-1];
          if (period == '0) begin
            rad   <= tick_count[TW-1] ? (RW'(0) - zcpd_pkg::PI_Q13) : zcpd_pkg::PI_Q13;
            state <= S_DEG;
          end else begin
            prod  <= zcpd_pkg::PROD_W'(tick_mag) * zcpd_pkg::PROD_W'(zcpd_pkg::TWOPI_Q29);
            state <= S_ADD;
          end
        end
        S_ADD: begin
          div_rem <= '0;
          div_dvd <= prod_rnd[zcpd_pkg::PROD_W-1:zcpd_pkg::PROD_W-DIV_W];
          div_den <= DV_W'(period);
          div_quo <= '0;
          div_cnt <= zcpd_pkg::PHASE_STEPS;
          state   <= S_DIV_P;
        end
        S_DIV_P: begin
          if (div_last) begin
            rad   <= rad_p;
            state <= S_DEG;
          end
        end
        S_DEG: begin
          if (out_load) begin
            out_valid <= 1'b1;
            out_rad   <= rad;
            out_deg   <= deg;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign phase.valid         = out_valid;
  assign phase.phase_radians = out_rad;
  assign phase.phase_degrees = out_deg;

  a_div_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_A || state == S_DIV_B || state == S_DIV_P) |-> (div_rem < div_den))
    else $error("divider remainder not below divisor");

  a_rad_in_range: assert property (@(posedge clk) disable iff (rst)
    phase.valid |-> ($signed(phase.phase_radians) <= $signed(zcpd_pkg::PI_Q13) &&
                     $signed(phase.phase_radians) >= -$signed(zcpd_pkg::PI_Q13)))
    else $error("phase radians outside plus/minus pi");

  a_deg_in_range: assert property (@(posedge clk) disable iff (rst)
    phase.valid |-> ($signed(phase.phase_degrees) <= 15'sd11520 &&
                     $signed(phase.phase_degrees) >= -15'sd11520))
    else $error("phase degrees outside plus/minus 180");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (phase.valid && state == S_IDLE))
    else $error("phase result not presented after load");

endmodule
